[design/trs_pkg.sv]
// shared types, codes and helpers for the triangle rasterizer
`timescale 1ns / 1ps
package trs_pkg;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // vertex slot that completes a triangle
  localparam logic [1:0] SLOT_LAST = 2'd2;

  typedef enum logic [1:0] {
    F_RUN,
    F_BOX,
    F_EDGE
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_COMB,
    B_WMUL,
    B_DIV,
    B_DONE
  } back_state_e;

  // one visited pixel with the vertex data used to shade it
  typedef struct packed {
    logic [10:0]      px;
    logic [10:0]      py;
    logic             covered;
    logic             last;
    logic [2:0][15:0] vx;
    logic [2:0][15:0] vy;
    logic [2:0][12:0] vu;
    logic [2:0][12:0] vv;
  } job_t;

  // Q12.4 to whole pixel, truncated toward zero
  function automatic logic signed [11:0] trunc_pix(input logic signed [15:0] v);
    logic signed [15:0] t;
    t = v[15] ? (v + 16'sd15) : v;
    return t[15:4];
  endfunction

endpackage

[design/trs_in_if.sv]
// input channel: vertex loads and pixel steps
`timescale 1ns / 1ps
interface trs_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [1:0]         slot;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [12:0]        tex_u;
  logic [12:0]        tex_v;

  modport source (output valid, kind, slot, pos_x, pos_y, tex_u, tex_v, input ready);
  modport sink (input valid, kind, slot, pos_x, pos_y, tex_u, tex_v, output ready);
endinterface

[design/trs_out_if.sv]
// output channel: one shaded pixel per transaction
`timescale 1ns / 1ps
interface trs_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] pix_x;
  logic [7:0] pix_y;
  logic       covered;
  logic [7:0] red;
  logic [7:0] green;
  logic       last;

  modport source (output valid, pix_x, pix_y, covered, red, green, last, input ready);
  modport sink (input valid, pix_x, pix_y, covered, red, green, last, output ready);
endinterface

[design/trs_front.sv]
// front end: vertex store, triangle set-up and bounding box walk
`timescale 1ns / 1ps
module trs_front #(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  trs_in_if.sink        in_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output trs_pkg::job_t job_o
);

  localparam logic signed [11:0] XLIM = 12'(SCREEN_W - 1);
  localparam logic signed [11:0] YLIM = 12'(SCREEN_H - 1);

  trs_pkg::front_state_e state_q, state_d;

  logic [15:0] vert_x_q [3];
  logic [15:0] vert_y_q [3];
  logic [12:0] vert_u_q [3];
  logic [12:0] vert_v_q [3];

  logic signed [11:0] xi_q [3];
  logic signed [11:0] yi_q [3];
  logic signed [11:0] xi_c [3];
  logic signed [11:0] yi_c [3];
  logic signed [11:0] xmin_c, xmax_c, ymin_c, ymax_c, mn_x, mx_x, mn_y, mx_y;

  logic signed [13:0] edge_dx_q [3];
  logic signed [13:0] edge_dy_q [3];
  logic signed [31:0] edge_row_q [3];
  logic signed [31:0] edge_pix_q [3];

  logic signed [11:0] walk_x_q, walk_y_q, box_left_q, box_right_q, box_bottom_q, ymin_q;
  logic               walking_q, box_ok_q;
  logic [1:0]         edge_idx_q;
  logic               phase_q;
  logic signed [31:0] prod_a_q;

  logic               accept, load, step, fin, cov;
  logic signed [11:0] xa, ya, xb, yb;
  logic signed [12:0] dx_c, dy_c, ydist, xdist;
  logic signed [25:0] prod_a, prod_b;
  logic signed [31:0] s_c;

  // handshake
  assign in_i.ready  = (state_q == trs_pkg::F_RUN) && job_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign load        = accept && (in_i.kind == trs_pkg::KIND_LOAD)
                       && (in_i.slot <= trs_pkg::SLOT_LAST);
  assign step        = accept && (in_i.kind == trs_pkg::KIND_STEP) && walking_q;
  assign job_valid_o = step;

  // pixel classification
  assign cov = (edge_pix_q[0] > 32'sd0) && (edge_pix_q[1] > 32'sd0)
               && (edge_pix_q[2] > 32'sd0);
  assign fin = (walk_x_q == box_right_q) && (walk_y_q == box_bottom_q);

  always_comb begin
    job_o.px      = walk_x_q[10:0];
    job_o.py      = walk_y_q[10:0];
    job_o.covered = cov;
    job_o.last    = fin;
    for (int k = 0; k < 3; k++) begin
      job_o.vx[k] = vert_x_q[k];
      job_o.vy[k] = vert_y_q[k];
      job_o.vu[k] = vert_u_q[k];
      job_o.vv[k] = vert_v_q[k];
    end
  end

  // bounding box of the truncated vertices
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xi_c[k] = trs_pkg::trunc_pix(vert_x_q[k]);
      yi_c[k] = trs_pkg::trunc_pix(vert_y_q[k]);
    end
    mn_x = (xi_c[0] < xi_c[1]) ? xi_c[0] : xi_c[1];
    mn_x = (xi_c[2] < mn_x) ? xi_c[2] : mn_x;
    mx_x = (xi_c[0] > xi_c[1]) ? xi_c[0] : xi_c[1];
    mx_x = (xi_c[2] > mx_x) ? xi_c[2] : mx_x;
    mn_y = (yi_c[0] < yi_c[1]) ? yi_c[0] : yi_c[1];
    mn_y = (yi_c[2] < mn_y) ? yi_c[2] : mn_y;
    mx_y = (yi_c[0] > yi_c[1]) ? yi_c[0] : yi_c[1];
    mx_y = (yi_c[2] > mx_y) ? yi_c[2] : mx_y;
    xmin_c = (mn_x < 12'sd0) ? 12'sd0 : mn_x;
    xmax_c = (mx_x > XLIM) ? XLIM : mx_x;
    ymin_c = (mn_y < 12'sd0) ? 12'sd0 : mn_y;
    ymax_c = (mx_y > YLIM) ? YLIM : mx_y;
  end

  // edge set-up operands, vertex i and its successor
  always_comb begin
    unique case (edge_idx_q)
      2'd0: begin
        xa = xi_q[0]; ya = yi_q[0]; xb = xi_q[1]; yb = yi_q[1];
      end
      2'd1: begin
        xa = xi_q[1]; ya = yi_q[1]; xb = xi_q[2]; yb = yi_q[2];
      end
      default: begin
        xa = xi_q[2]; ya = yi_q[2]; xb = xi_q[0]; yb = yi_q[0];
      end
    endcase
    dx_c   = 13'(ya) - 13'(yb);
    dy_c   = 13'(xa) - 13'(xb);
    ydist  = 13'(ymin_q) - 13'(ya);
    xdist  = 13'(box_left_q) - 13'(xa);
    prod_a = dy_c * ydist;
    prod_b = dx_c * xdist;
    s_c    = prod_a_q - 32'(prod_b);
    if ((dx_c < 13'sd0) || ((dx_c == 13'sd0) && (dy_c > 13'sd0))) begin
      s_c = s_c + 32'sd1;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trs_pkg::F_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trs_pkg::F_RUN: begin
        if (load && (in_i.slot == trs_pkg::SLOT_LAST)) state_d = trs_pkg::F_BOX;
      end
      trs_pkg::F_BOX: state_d = trs_pkg::F_EDGE;
      trs_pkg::F_EDGE: begin
        if ((edge_idx_q == 2'd2) && phase_q) state_d = trs_pkg::F_RUN;
      end
      default: state_d = trs_pkg::F_RUN;
    endcase
  end

  // walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walking_q  <= 1'b0;
      edge_idx_q <= 2'd0;
      phase_q    <= 1'b0;
    end else begin
      if (load && (in_i.slot == trs_pkg::SLOT_LAST)) begin
        walking_q <= 1'b0;
      end else if (step && fin && !(walk_x_q < box_right_q)) begin
        walking_q <= 1'b0;
      end else if ((state_q == trs_pkg::F_EDGE) && (edge_idx_q == 2'd2) && phase_q) begin
        walking_q <= box_ok_q;
      end
      if (state_q == trs_pkg::F_BOX) begin
        edge_idx_q <= 2'd0;
        phase_q    <= 1'b0;
      end else if (state_q == trs_pkg::F_EDGE) begin
        phase_q <= !phase_q;
        if (phase_q) edge_idx_q <= edge_idx_q + 2'd1;
      end
    end
  end

  // vertex store, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        vert_x_q[k] <= 16'd0;
        vert_y_q[k] <= 16'd0;
        vert_u_q[k] <= 13'd0;
        vert_v_q[k] <= 13'd0;
      end
    end else if (load) begin
      vert_x_q[in_i.slot] <= in_i.pos_x;
      vert_y_q[in_i.slot] <= in_i.pos_y;
      vert_u_q[in_i.slot] <= in_i.tex_u;
      vert_v_q[in_i.slot] <= in_i.tex_v;
    end
  end

  // set-up and walk datapath
  always_ff @(posedge clk_i) begin
    if (state_q == trs_pkg::F_BOX) begin
      for (int k = 0; k < 3; k++) begin
        xi_q[k] <= xi_c[k];
        yi_q[k] <= yi_c[k];
      end
      box_left_q   <= xmin_c;
      box_right_q  <= xmax_c;
      box_bottom_q <= ymax_c;
      ymin_q       <= ymin_c;
      walk_x_q     <= xmin_c;
      walk_y_q     <= ymin_c;
      box_ok_q     <= (xmin_c <= xmax_c) && (ymin_c <= ymax_c);
    end
    if (state_q == trs_pkg::F_EDGE) begin
      if (!phase_q) begin
        prod_a_q <= 32'(prod_a);
      end else begin
        edge_dx_q[edge_idx_q]  <= 14'(dx_c);
        edge_dy_q[edge_idx_q]  <= 14'(dy_c);
        edge_row_q[edge_idx_q] <= s_c;
        edge_pix_q[edge_idx_q] <= s_c;
      end
    end
    if (step) begin
      if (walk_x_q < box_right_q) begin
        walk_x_q <= walk_x_q + 12'sd1;
        for (int k = 0; k < 3; k++) begin
          edge_pix_q[k] <= edge_pix_q[k] - 32'(edge_dx_q[k]);
        end
      end else if (!fin) begin
        walk_x_q <= box_left_q;
        walk_y_q <= walk_y_q + 12'sd1;
        for (int k = 0; k < 3; k++) begin
          edge_row_q[k] <= edge_row_q[k] + 32'(edge_dy_q[k]);
          edge_pix_q[k] <= edge_row_q[k] + 32'(edge_dy_q[k]);
        end
      end
    end
  end

  // checks
  a_setup_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != trs_pkg::F_RUN) |-> !in_i.ready)
    else $error("input taken during triangle set-up");

  a_walk_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walking_q |-> ((walk_x_q <= box_right_q) && (walk_x_q >= box_left_q)
                   && (walk_y_q <= box_bottom_q)))
    else $error("walk position left the bounding box");

  a_new_tri_stops_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (in_i.slot == trs_pkg::SLOT_LAST)) |=> !walking_q)
    else $error("walk still running during set-up");

endmodule

[design/trs_queue.sv]
// two-entry pixel queue between front and back end
`timescale 1ns / 1ps
module trs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  trs_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output trs_pkg::job_t pop_job_o
);

  trs_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_job_i;
  end

endmodule

[design/trs_back.sv]
// back end: barycentric shading with shared multipliers and a serial divider
`timescale 1ns / 1ps
module trs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  trs_pkg::job_t job_i,
  trs_out_if.source     out_o
);

  trs_pkg::back_state_e state_q, state_d;

  trs_pkg::job_t      job_q;
  logic [2:0]         mcnt_q;
  logic [3:0]         div_cnt_q;
  logic               ch_q;
  logic signed [35:0] prod_q [6];
  logic [36:0]        d_q;
  logic [36:0]        w_q [3];
  logic [51:0]        su_q, sv_q;
  logic [59:0]        rem_q, dsh_q;
  logic [7:0]         quo_q, red_q, green_q;
  logic               out_valid_q;

  logic               pop, done_fire;
  logic signed [17:0] v0x, v0y, v1x, v1y, v2x, v2y, ma, mb;
  logic signed [35:0] mprod;
  logic signed [36:0] d_s, nb_s, nc_s;
  logic signed [37:0] d38, nb38, nc38;
  logic signed [39:0] wa_raw;
  logic [36:0]        wa_c, wb_c, wc_c, dd_c;
  logic [36:0]        wsel;
  logic [12:0]        tsel;
  logic [49:0]        wprod;
  logic               ge, fin_div, sat;
  logic [7:0]         qn, res;

  function automatic logic signed [17:0] sx18(input logic [15:0] v);
    return 18'(signed'(v));
  endfunction

  function automatic logic [36:0] clamp_w(input logic signed [39:0] n,
                                          input logic signed [39:0] dmax);
    logic [36:0] r;
    if (n < 40'sd0) r = 37'd0;
    else if (n > dmax) r = dmax[36:0];
    else r = n[36:0];
    return r;
  endfunction

  function automatic logic [59:0] num_of(input logic [51:0] s);
    return {s, 8'd0} - {8'd0, s};
  endfunction

  assign job_ready_o = (state_q == trs_pkg::B_IDLE);
  assign pop         = job_valid_i && job_ready_o;
  assign done_fire   = (state_q == trs_pkg::B_DONE) && (!out_valid_q || out_o.ready);

  // vectors relative to vertex 0, pixel centre in Q12.4
  always_comb begin
    v0x = sx18(job_q.vx[1]) - sx18(job_q.vx[0]);
    v0y = sx18(job_q.vy[1]) - sx18(job_q.vy[0]);
    v1x = sx18(job_q.vx[2]) - sx18(job_q.vx[0]);
    v1y = sx18(job_q.vy[2]) - sx18(job_q.vy[0]);
    v2x = signed'({3'd0, job_q.px, 4'd8}) - sx18(job_q.vx[0]);
    v2y = signed'({3'd0, job_q.py, 4'd8}) - sx18(job_q.vy[0]);
  end

  // shared cross-product multiplier
  always_comb begin
    case (mcnt_q)
      3'd0:    begin ma = v0x; mb = v1y; end
      3'd1:    begin ma = v0y; mb = v1x; end
      3'd2:    begin ma = v2x; mb = v1y; end
      3'd3:    begin ma = v2y; mb = v1x; end
      3'd4:    begin ma = v0x; mb = v2y; end
      default: begin ma = v0y; mb = v2x; end
    endcase
    mprod = ma * mb;
  end

  // area, sign fix and clamped weights
  always_comb begin
    d_s    = 37'(prod_q[0]) - 37'(prod_q[1]);
    nb_s   = 37'(prod_q[2]) - 37'(prod_q[3]);
    nc_s   = 37'(prod_q[4]) - 37'(prod_q[5]);
    d38    = d_s[36] ? -38'(d_s) : 38'(d_s);
    nb38   = d_s[36] ? -38'(nb_s) : 38'(nb_s);
    nc38   = d_s[36] ? -38'(nc_s) : 38'(nc_s);
    wa_raw = 40'(d38) - 40'(nb38) - 40'(nc38);
    if (d_s == 37'sd0) begin
      dd_c = 37'd1;
      wa_c = 37'd1;
      wb_c = 37'd0;
      wc_c = 37'd0;
    end else begin
      dd_c = d38[36:0];
      wa_c = clamp_w(wa_raw, 40'(d38));
      wb_c = clamp_w(40'(nb38), 40'(d38));
      wc_c = clamp_w(40'(nc38), 40'(d38));
    end
  end

  // weight times texture multiplier
  always_comb begin
    case (mcnt_q)
      3'd0:    begin wsel = w_q[0]; tsel = job_q.vu[0]; end
      3'd1:    begin wsel = w_q[1]; tsel = job_q.vu[1]; end
      3'd2:    begin wsel = w_q[2]; tsel = job_q.vu[2]; end
      3'd3:    begin wsel = w_q[0]; tsel = job_q.vv[0]; end
      3'd4:    begin wsel = w_q[1]; tsel = job_q.vv[1]; end
      default: begin wsel = w_q[2]; tsel = job_q.vv[2]; end
    endcase
    wprod = 50'(wsel) * 50'(tsel);
  end

  // restoring divider step, first step detects saturation
  always_comb begin
    ge      = (rem_q >= dsh_q);
    qn      = {quo_q[6:0], ge};
    sat     = (div_cnt_q == 4'd0) && ge;
    fin_div = sat || (div_cnt_q == 4'd8);
    res     = sat ? 8'hFF : qn;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trs_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trs_pkg::B_IDLE: begin
        if (pop) state_d = job_i.covered ? trs_pkg::B_MUL : trs_pkg::B_DONE;
      end
      trs_pkg::B_MUL: begin
        if (mcnt_q == 3'd5) state_d = trs_pkg::B_COMB;
      end
      trs_pkg::B_COMB: state_d = trs_pkg::B_WMUL;
      trs_pkg::B_WMUL: begin
        if (mcnt_q == 3'd5) state_d = trs_pkg::B_DIV;
      end
      trs_pkg::B_DIV: begin
        if (fin_div && ch_q) state_d = trs_pkg::B_DONE;
      end
      trs_pkg::B_DONE: begin
        if (done_fire) state_d = trs_pkg::B_IDLE;
      end
      default: state_d = trs_pkg::B_IDLE;
    endcase
  end

  // shading datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      trs_pkg::B_IDLE: begin
        if (pop) begin
          job_q   <= job_i;
          mcnt_q  <= 3'd0;
          red_q   <= 8'd0;
          green_q <= 8'd0;
        end
      end
      trs_pkg::B_MUL: begin
        prod_q[mcnt_q] <= mprod;
        mcnt_q         <= (mcnt_q == 3'd5) ? 3'd0 : mcnt_q + 3'd1;
      end
      trs_pkg::B_COMB: begin
        d_q    <= dd_c;
        w_q[0] <= wa_c;
        w_q[1] <= wb_c;
        w_q[2] <= wc_c;
        su_q   <= 52'd0;
        sv_q   <= 52'd0;
        mcnt_q <= 3'd0;
      end
      trs_pkg::B_WMUL: begin
        if (mcnt_q < 3'd3) su_q <= su_q + 52'(wprod);
        else sv_q <= sv_q + 52'(wprod);
        mcnt_q <= mcnt_q + 3'd1;
        if (mcnt_q == 3'd5) begin
          rem_q     <= num_of(su_q);
          dsh_q     <= {3'd0, d_q, 20'd0};
          quo_q     <= 8'd0;
          div_cnt_q <= 4'd0;
          ch_q      <= 1'b0;
        end
      end
      trs_pkg::B_DIV: begin
        if (fin_div) begin
          if (!ch_q) begin
            red_q <= res;
          end else begin
            green_q <= res;
          end
          rem_q     <= num_of(sv_q);
          dsh_q     <= {3'd0, d_q, 20'd0};
          quo_q     <= 8'd0;
          div_cnt_q <= 4'd0;
          ch_q      <= 1'b1;
        end else begin
          quo_q     <= qn;
          rem_q     <= ge ? (rem_q - dsh_q) : rem_q;
          dsh_q     <= {1'b0, dsh_q[59:1]};
          div_cnt_q <= div_cnt_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_o.pix_x   <= job_q.px[8:0];
      out_o.pix_y   <= job_q.py[7:0];
      out_o.covered <= job_q.covered;
      out_o.last    <= job_q.last;
      out_o.red     <= red_q;
      out_o.green   <= green_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // checks
  a_uncovered_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.covered) |-> ((out_o.red == 8'd0) && (out_o.green == 8'd0)))
    else $error("uncovered pixel carries colour");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trs_pkg::B_DIV) |-> (div_cnt_q <= 4'd8))
    else $error("divider ran past its last step");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q != trs_pkg::B_IDLE))
    else $error("popped pixel not processed");

endmodule

[design/triangle_rasterizer.sv]
// A vertex load is stored when taken. Loading slot 2 runs a set-up (box, then two
// multiplies per edge) during which no transaction is taken.
// A step is pushed into a two-entry queue. For a covered pixel the shading back
// end forms 6 cross products, then 6 weight products, then two restoring divides;
// an uncovered pixel goes straight to the output register. Reset clears the
// walk flag and the state machines; no clearing pass is needed.
`timescale 1ns / 1ps
module triangle_rasterizer #(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  trs_in_if.sink    in_i,
  trs_out_if.source out_o
);

  logic          f_valid, f_ready, b_valid, b_ready;
  trs_pkg::job_t f_job, b_job;

  // set-up and walk
  trs_front #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  // decoupling queue
  trs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_job_i   (f_job),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_job_o    (b_job)
  );

  // shading
  trs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .out_o       (out_o)
  );

endmodule
